[rtl/sis_pkg.sv]
// Shared constants and types for the stable insertion sorter.
`timescale 1ns / 1ps
package sis_pkg;

  localparam int CAPACITY     = 64;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int REC_BITS     = KEY_BITS + PAYLOAD_BITS;
  localparam int TDATA_W      = ((REC_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic                           valid;
    logic signed [KEY_BITS-1:0]     key;
    logic        [PAYLOAD_BITS-1:0] payload;
  } rec_t;

  typedef struct packed {
    logic ins;
    logic drain;
  } cell_ctrl_t;

endpackage

[rtl/stable_insertion_sorter_core.sv]
// Top level of the stable insertion sorter: cell chain and fill/drain control.
`timescale 1ns / 1ps
// Records enter one beat per cycle and are placed into a chain of CAPACITY
// cells: every cell compares its key with the incoming key in parallel and
// either holds, takes its left neighbor, or takes the new record, so equal
// keys keep arrival order. A beat with in_tlast set is inserted and then the
// chain drains from cell 0, one result beat per cycle while out_tready is
// high, shifting every cell one place down per beat; no input is taken
// during the drain. A set stores at most CAPACITY records. Records that
// arrive with the chain full are dropped and every result of that set
// carries the overflow flag in out_tuser.
module stable_insertion_sorter_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sis_pkg::TDATA_W-1:0] in_tdata,   // sort_key, payload, zero pad
  input  logic                        in_tlast,   // last_item
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sis_pkg::TDATA_W-1:0] out_tdata,  // sorted_key, sorted_payload, zero pad
  output logic                        out_tlast,  // end_of_set
  output logic                        out_tuser   // overflowed
);
  import sis_pkg::*;

  typedef enum logic [1:0] {
    S_FILL  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  logic       drop_r, drop_nxt;
  logic       in_acc, out_acc, full;
  rec_t       new_rec;
  cell_ctrl_t ctrl;
  rec_t       cells [CAPACITY];
  logic       gts   [CAPACITY];
  rec_t       empty_rec;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign full    = cells[CAPACITY-1].valid;

  assign new_rec.valid   = 1'b1;
  assign new_rec.key     = in_tdata[KEY_BITS-1:0];
  assign new_rec.payload = in_tdata[REC_BITS-1:KEY_BITS];

  assign empty_rec = '0;

  assign ctrl.ins   = in_acc && !full;
  assign ctrl.drain = out_acc;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rec_t left_rec, right_rec;
    logic left_gt;
    if (i == 0) begin : g_first
      assign left_rec = empty_rec;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_rec = cells[i-1];
      assign left_gt  = gts[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_rec = empty_rec;
    end else begin : g_inner
      assign right_rec = cells[i+1];
    end
    sis_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_rec   (new_rec),
      .left_rec  (left_rec),
      .left_gt   (left_gt),
      .right_rec (right_rec),
      .rec       (cells[i]),
      .gt        (gts[i])
    );
  end

  assign in_tready  = (state_r == S_FILL);
  assign out_tvalid = (state_r == S_DRAIN);
  assign out_tdata  = TDATA_W'({cells[0].payload, cells[0].key});
  assign out_tlast  = !cells[1].valid;
  assign out_tuser  = drop_r;

  always_comb begin
    state_nxt = state_r;
    drop_nxt  = drop_r;
    unique case (state_r)
      S_FILL: begin
        if (in_acc) begin
          if (full) begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (out_acc && out_tlast) begin
          state_nxt = S_FILL;
          drop_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

[rtl/sis_cell.sv]
// One cell of the insertion chain: holds one record, inserts, shifts or keeps it each cycle.
`timescale 1ns / 1ps
module sis_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  sis_pkg::cell_ctrl_t ctrl,
  input  sis_pkg::rec_t      new_rec,
  input  sis_pkg::rec_t      left_rec,
  input  logic               left_gt,
  input  sis_pkg::rec_t      right_rec,
  output sis_pkg::rec_t      rec,
  output logic               gt
);
  import sis_pkg::*;

  logic                           valid_r, valid_nxt;
  logic signed [KEY_BITS-1:0]     key_r, key_nxt;
  logic        [PAYLOAD_BITS-1:0] payload_r, payload_nxt;

  assign rec.valid   = valid_r;
  assign rec.key     = key_r;
  assign rec.payload = payload_r;

  assign gt = !valid_r || (key_r > new_rec.key);

  always_comb begin
    valid_nxt   = valid_r;
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (ctrl.drain) begin
      valid_nxt   = right_rec.valid;
      key_nxt     = right_rec.key;
      payload_nxt = right_rec.payload;
    end else if (ctrl.ins && gt) begin
      if (left_gt) begin
        valid_nxt   = left_rec.valid;
        key_nxt     = left_rec.key;
        payload_nxt = left_rec.payload;
      end else begin
        valid_nxt   = 1'b1;
        key_nxt     = new_rec.key;
        payload_nxt = new_rec.payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

endmodule

[tb/tb.sv]
// Testbench for the stable insertion sorter: queued stimulus, sorting predictor, result checks.
`timescale 1ns / 1ps
module tb;
  import sis_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 260;

  typedef struct {
    logic signed [KEY_BITS-1:0] key;
    logic [PAYLOAD_BITS-1:0] pay;
    logic last;
    bit hold;
  } beat_t;

  typedef struct {
    logic signed [KEY_BITS-1:0] key;
    logic [PAYLOAD_BITS-1:0] pay;
    logic eos;
    logic ovf;
  } sorted_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  beat_t pending_beats[$];
  beat_t cur_beat;
  sorted_rec_t sorted_store[$];
  sorted_rec_t sorted_due[$];
  bit drop_flag;
  int gap_left;
  int stall_left;
  bit in_calm;
  bit out_calm;
  int err_cnt;
  int items_taken;
  int results_seen;
  int sets_done;
  int ovf_sets;
  int cycle_cnt;

  stable_insertion_sorter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic insert_record(input beat_t b);
    sorted_rec_t r;
    int pos;
    r.key = b.key;
    r.pay = b.pay;
    r.eos = 1'b0;
    r.ovf = 1'b0;
    items_taken++;
    if (sorted_store.size() < CAPACITY) begin
      pos = sorted_store.size();
      for (int i = 0; i < sorted_store.size(); i++) begin
        if (sorted_store[i].key > b.key) begin
          pos = i;
          break;
        end
      end
      sorted_store.insert(pos, r);
    end else begin
      drop_flag = 1'b1;
    end
    if (b.last) begin
      foreach (sorted_store[i]) begin
        r = sorted_store[i];
        r.eos = (i == sorted_store.size() - 1);
        r.ovf = drop_flag;
        sorted_due.push_back(r);
      end
      sets_done++;
      if (drop_flag) ovf_sets++;
      sorted_store.delete();
      drop_flag = 1'b0;
    end
  endtask

  task automatic check_result();
    sorted_rec_t want;
    logic signed [KEY_BITS-1:0] got_key;
    logic [PAYLOAD_BITS-1:0] got_pay;
    got_key = out_tdata[KEY_BITS-1:0];
    got_pay = out_tdata[KEY_BITS +: PAYLOAD_BITS];
    results_seen++;
    if (sorted_due.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("%0t unexpected result beat: key %0d payload %h last %b ovf %b",
                 $realtime, got_key, got_pay, out_tlast, out_tuser);
      return;
    end
    want = sorted_due.pop_front();
    if (got_key !== want.key || got_pay !== want.pay || out_tlast !== want.eos ||
        out_tuser !== want.ovf) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("%0t mismatch: expected key %0d payload %h last %b ovf %b, %s",
                 $realtime, want.key, want.pay, want.eos, want.ovf,
                 $sformatf("got key %0d payload %h last %b ovf %b",
                           got_key, got_pay, out_tlast, out_tuser));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        insert_record(cur_beat);
        gap_left = in_calm ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0 &&
                     (!pending_beats[0].hold || sorted_due.size() == 0)) begin
          cur_beat = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {cur_beat.pay, cur_beat.key};
          in_tlast <= cur_beat.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_result();
        stall_left = out_calm ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic void queue_beat(input int key, input int pay, input bit last,
                                     input bit hold = 1'b0);
    beat_t b;
    b.key = key[KEY_BITS-1:0];
    b.pay = pay[PAYLOAD_BITS-1:0];
    b.last = last;
    b.hold = hold;
    pending_beats.push_back(b);
  endfunction

  function automatic int draw_key(input int flavor);
    case (flavor)
      1: return $urandom_range(0, 4) - 2;
      2: begin
        case ($urandom_range(0, 3))
          0: return -32768;
          1: return 32767;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  function automatic int queue_random_set(input int len, input bit hold);
    int flavor;
    flavor = $urandom_range(0, 3);
    for (int i = 0; i < len; i++)
      queue_beat(draw_key(flavor), $urandom_range(0, 65535), i == len - 1, hold && i == 0);
    return len;
  endfunction

  initial begin
    int sent;
    int len;
    bit timed_out;
    // directed: single-record sets at both key extremes
    queue_beat(-32768, 16'h0000, 1'b1, 1'b1);
    queue_beat(32767, 16'hffff, 1'b1);
    // extremes mixed with a tie on zero
    queue_beat(32767, 16'h0001, 1'b0, 1'b1);
    queue_beat(-32768, 16'h0002, 1'b0);
    queue_beat(0, 16'h0003, 1'b0);
    queue_beat(-1, 16'h0004, 1'b0);
    queue_beat(1, 16'h0005, 1'b0);
    queue_beat(0, 16'h0006, 1'b1);
    // equal keys must keep arrival order
    for (int i = 0; i < 5; i++) queue_beat(7, 16'ha000 + i, i == 4);
    // strictly descending input
    for (int i = 0; i < 5; i++) queue_beat(100 - 10 * i, 16'h5a50 + i, i == 4);
    // exactly full, then full with the last record dropped
    sent = queue_random_set(CAPACITY, 1'b1);
    sent += queue_random_set(CAPACITY + 1, 1'b0);
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 8)
                                        : $urandom_range(1, 12);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      sent += queue_random_set(len, $urandom_range(0, 7) == 0);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    cycle_cnt = 0;
    while ((pending_beats.size() != 0 || in_tvalid || sorted_due.size() != 0) &&
           cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    timed_out = (cycle_cnt >= CYCLE_LIMIT);
    if (!timed_out) repeat (CAPACITY + 8) @(posedge clk);

    $display("Sorted %0d sets from %0d input beats, %0d of them with dropped records.",
             sets_done, items_taken, ovf_sets);
    $display("Checked %0d result beats, %0d mismatches.", results_seen, err_cnt);
    if (!timed_out && err_cnt == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
